// ----- rtl/rls_pkg.sv -----
// Shared types, register indexes and step tables for the lattice successor unit.
package rls_pkg;

  typedef struct packed {
    logic [14:0]        abs_s;
    logic signed [15:0] north_s;
    logic signed [15:0] northeast_s;
    logic signed [15:0] east_s;
    logic signed [15:0] southeast_s;
    logic [15:0]        comms;
  } cell_t;

  typedef struct packed {
    logic turn_ok;
    logic slope_ok;
    logic comms_ok;
  } chk_res_t;

  localparam logic [2:0] CFG_TURN  = 3'd0;
  localparam logic [2:0] CFG_LON   = 3'd1;
  localparam logic [2:0] CFG_LAT   = 3'd2;
  localparam logic [2:0] CFG_COMMS = 3'd3;
  localparam logic [2:0] CFG_ROWS  = 3'd4;
  localparam logic [2:0] CFG_COLS  = 3'd5;

  localparam logic [14:0] TURN_RST  = 15'd2560;
  localparam logic [14:0] LON_RST   = 15'd5120;
  localparam logic [14:0] LAT_RST   = 15'd5120;
  localparam logic [15:0] COMMS_RST = 16'hFFFF;
  localparam logic [8:0]  DIM_RST   = 9'd256;

  // row offset of one step along a heading
  function automatic logic signed [1:0] step_dr(input logic [2:0] h);
    logic signed [1:0] d;
    unique case (h)
      3'd0, 3'd1, 3'd7: d = -2'sd1;
      3'd2, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // column offset of one step along a heading
  function automatic logic signed [1:0] step_dc(input logic [2:0] h);
    logic signed [1:0] d;
    unique case (h)
      3'd1, 3'd2, 3'd3: d = 2'sd1;
      3'd0, 3'd4:       d = 2'sd0;
      default:          d = -2'sd1;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/rls_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/rls_cell_check.sv -----
// Shared compare unit: slope, comms and point-turn limits of one cell.
module rls_cell_check
  import rls_pkg::*;
(
  input  cell_t       site,
  input  logic [2:0]  heading,
  input  logic [14:0] turn_lim,
  input  logic [14:0] lon_lim,
  input  logic [14:0] lat_lim,
  input  logic [15:0] comms_lim,
  output chk_res_t    res
);

  logic signed [15:0] lon_s;
  logic signed [15:0] lat_s;
  logic [15:0]        lon_mag;
  logic [15:0]        lat_mag;

  // sign is irrelevant, so lon/lat pick by heading mod 4
  always_comb begin
    unique case (heading[1:0])
      2'd0: begin
        lon_s = site.north_s;
        lat_s = site.east_s;
      end
      2'd1: begin
        lon_s = site.northeast_s;
        lat_s = site.southeast_s;
      end
      2'd2: begin
        lon_s = site.east_s;
        lat_s = site.north_s;
      end
      default: begin
        lon_s = site.southeast_s;
        lat_s = site.northeast_s;
      end
    endcase
  end

  assign lon_mag = lon_s[15] ? 16'(-lon_s) : 16'(lon_s);
  assign lat_mag = lat_s[15] ? 16'(-lat_s) : 16'(lat_s);

  assign res.turn_ok  = site.abs_s <= turn_lim;
  assign res.slope_ok = (lon_mag <= {1'b0, lon_lim}) && (lat_mag <= {1'b0, lat_lim});
  assign res.comms_ok = site.comms <= comms_lim;

endmodule

// ----- rtl/rover_lattice_successors_unit.sv -----
// Top level: terrain store, query sequencer and result register.
// Load: accepted whenever idle, never sets busy; loads may follow each other every cycle.
// Query: three reads of the terrain RAM (current, forward, backward cell), one per cycle,
//   then one result per cycle; busy in S_CUR, S_FWD, S_BWD and S_EMIT (n = 1..4 results).
// The first result is registered in S_EMIT after S_CUR, S_FWD, S_BWD; results of a query
//   come on consecutive cycles and the receiver cannot stall them.
// Synchronous reset clears control and limit registers; the terrain store is not cleared.
module rover_lattice_successors_unit
  import rls_pkg::*;
#(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [7:0]         in_cell_row,
  input  logic [7:0]         in_cell_col,
  input  logic [2:0]         in_heading,
  input  logic [14:0]        in_abs_slope,
  input  logic signed [15:0] in_north_slope,
  input  logic signed [15:0] in_northeast_slope,
  input  logic signed [15:0] in_east_slope,
  input  logic signed [15:0] in_southeast_slope,
  input  logic [15:0]        in_comms_distance,
  output logic               out_valid,
  output logic [7:0]         out_succ_row,
  output logic [7:0]         out_succ_col,
  output logic [2:0]         out_succ_heading,
  output logic               out_empty_res,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int ST_ROWS = (MAX_ROWS < 256) ? MAX_ROWS : 256;
  localparam int ST_COLS = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int RW      = $clog2(ST_ROWS);
  localparam int CW      = $clog2(ST_COLS);
  localparam int AW      = RW + CW;
  localparam int DEPTH   = 2 ** AW;
  localparam logic [8:0] ST_ROWS_W = 9'(ST_ROWS);
  localparam logic [8:0] ST_COLS_W = 9'(ST_COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR,
    S_FWD,
    S_BWD,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [14:0] turn_lim_r;
  logic [14:0] lon_lim_r;
  logic [14:0] lat_lim_r;
  logic [15:0] comms_lim_r;
  logic [8:0]  rows_cfg_r;
  logic [8:0]  cols_cfg_r;

  logic [7:0] q_row_r;
  logic [7:0] q_col_r;
  logic [2:0] q_head_r;
  logic       cur_out_r;
  logic       cur_ok_r;
  logic [3:0] mask_r;
  logic [3:0] mask_nxt;

  logic       out_valid_r;
  logic [7:0] out_row_r;
  logic [7:0] out_col_r;
  logic [2:0] out_head_r;
  logic       out_empty_r;
  logic       out_last_r;

  logic       accept;
  logic       in_store;
  logic       ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  cell_t      wr_cell;
  cell_t      rd_cell;
  cell_t      chk_cell;
  chk_res_t   chk;

  logic [8:0] rows_b;
  logic [8:0] cols_b;
  logic signed [9:0] fr;
  logic signed [9:0] fc;
  logic signed [9:0] br;
  logic signed [9:0] bc;
  logic       fwd_inb;
  logic       bwd_inb;

  logic [1:0] sel;
  logic [7:0] sel_row;
  logic [7:0] sel_col;
  logic [2:0] sel_head;

  assign accept   = start && !busy;
  assign busy     = state_r != S_IDLE;
  assign in_store = ({1'b0, in_cell_row} < ST_ROWS_W) && ({1'b0, in_cell_col} < ST_COLS_W);

  assign wr_cell.abs_s       = in_abs_slope;
  assign wr_cell.north_s     = in_north_slope;
  assign wr_cell.northeast_s = in_northeast_slope;
  assign wr_cell.east_s      = in_east_slope;
  assign wr_cell.southeast_s = in_southeast_slope;
  assign wr_cell.comms       = in_comms_distance;

  assign ram_we    = accept && !in_op && in_store;
  assign ram_waddr = {in_cell_row[RW-1:0], in_cell_col[CW-1:0]};

  assign rows_b = (rows_cfg_r > ST_ROWS_W) ? ST_ROWS_W : rows_cfg_r;
  assign cols_b = (cols_cfg_r > ST_COLS_W) ? ST_COLS_W : cols_cfg_r;

  assign fr = $signed({2'b00, q_row_r}) + 10'(step_dr(q_head_r));
  assign fc = $signed({2'b00, q_col_r}) + 10'(step_dc(q_head_r));
  assign br = $signed({2'b00, q_row_r}) - 10'(step_dr(q_head_r));
  assign bc = $signed({2'b00, q_col_r}) - 10'(step_dc(q_head_r));

  assign fwd_inb = !fr[9] && !fc[9] && (fr[8:0] < rows_b) && (fc[8:0] < cols_b);
  assign bwd_inb = !br[9] && !bc[9] && (br[8:0] < rows_b) && (bc[8:0] < cols_b);

  always_comb begin
    priority case (state_r)
      S_CUR:   ram_raddr = {fr[RW-1:0], fc[CW-1:0]};
      S_FWD:   ram_raddr = {br[RW-1:0], bc[CW-1:0]};
      default: ram_raddr = {in_cell_row[RW-1:0], in_cell_col[CW-1:0]};
    endcase
  end

  rls_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_cell),
    .raddr (ram_raddr),
    .rdata (rd_cell)
  );

  // query cell outside the store reads as zero
  assign chk_cell = (state_r == S_CUR && cur_out_r) ? '0 : rd_cell;

  rls_cell_check u_check (
    .site      (chk_cell),
    .heading   (q_head_r),
    .turn_lim  (turn_lim_r),
    .lon_lim   (lon_lim_r),
    .lat_lim   (lat_lim_r),
    .comms_lim (comms_lim_r),
    .res       (chk)
  );

  always_comb begin
    priority if (mask_r[0]) begin
      sel = 2'd0;
    end else if (mask_r[1]) begin
      sel = 2'd1;
    end else if (mask_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_comb begin
    mask_nxt      = mask_r;
    mask_nxt[sel] = 1'b0;
    unique case (sel)
      2'd0: begin
        sel_row  = q_row_r;
        sel_col  = q_col_r;
        sel_head = q_head_r - 3'd1;
      end
      2'd1: begin
        sel_row  = q_row_r;
        sel_col  = q_col_r;
        sel_head = q_head_r + 3'd1;
      end
      2'd2: begin
        sel_row  = fr[7:0];
        sel_col  = fc[7:0];
        sel_head = q_head_r;
      end
      default: begin
        sel_row  = br[7:0];
        sel_col  = bc[7:0];
        sel_head = q_head_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_lim_r  <= TURN_RST;
      lon_lim_r   <= LON_RST;
      lat_lim_r   <= LAT_RST;
      comms_lim_r <= COMMS_RST;
      rows_cfg_r  <= DIM_RST;
      cols_cfg_r  <= DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TURN:  turn_lim_r  <= cfg_wdata[14:0];
        CFG_LON:   lon_lim_r   <= cfg_wdata[14:0];
        CFG_LAT:   lat_lim_r   <= cfg_wdata[14:0];
        CFG_COMMS: comms_lim_r <= cfg_wdata;
        CFG_ROWS:  rows_cfg_r  <= cfg_wdata[8:0];
        CFG_COLS:  cols_cfg_r  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      cur_ok_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_op) begin
            q_row_r   <= in_cell_row;
            q_col_r   <= in_cell_col;
            q_head_r  <= in_heading;
            cur_out_r <= !in_store;
            state_r   <= S_CUR;
          end
        end
        S_CUR: begin
          mask_r   <= {2'b00, chk.turn_ok, chk.turn_ok};
          cur_ok_r <= chk.slope_ok;
          state_r  <= S_FWD;
        end
        S_FWD: begin
          mask_r[2] <= cur_ok_r && fwd_inb && chk.slope_ok && chk.comms_ok;
          state_r   <= S_BWD;
        end
        S_BWD: begin
          mask_r[3] <= cur_ok_r && bwd_inb && chk.slope_ok && chk.comms_ok;
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          out_valid_r <= 1'b1;
          if (mask_r == 4'd0) begin
            out_row_r   <= '0;
            out_col_r   <= '0;
            out_head_r  <= '0;
            out_empty_r <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            out_row_r   <= sel_row;
            out_col_r   <= sel_col;
            out_head_r  <= sel_head;
            out_empty_r <= 1'b0;
            out_last_r  <= mask_nxt == 4'd0;
            mask_r      <= mask_nxt;
            if (mask_nxt == 4'd0) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_succ_row     = out_row_r;
  assign out_succ_col     = out_col_r;
  assign out_succ_heading = out_head_r;
  assign out_empty_res    = out_empty_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last)
    else $error("empty word without last");

  a_words_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && !out_empty_res)
    else $error("gap or empty word inside a query");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op |=> busy ##1 busy ##1 busy ##1 busy)
    else $error("query sequence too short");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EMIT))
    else $error("result word outside emit");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |->
      out_succ_row == 8'd0 && out_succ_col == 8'd0 && out_succ_heading == 3'd0)
    else $error("empty word carries a pose");
`endif

endmodule

// ----- dv/rls_tb_pkg.sv -----
// Operation codes shared by the lattice successor testbench and its checker.
package rls_tb_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

// ----- dv/rls_checker.sv -----
// Checker for the lattice successor unit: mirrors terrain and limits, predicts successor words.
module rls_checker
  import rls_pkg::*;
  import rls_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_op,
  input  logic [7:0]         in_cell_row,
  input  logic [7:0]         in_cell_col,
  input  logic [2:0]         in_heading,
  input  logic [14:0]        in_abs_slope,
  input  logic signed [15:0] in_north_slope,
  input  logic signed [15:0] in_northeast_slope,
  input  logic signed [15:0] in_east_slope,
  input  logic signed [15:0] in_southeast_slope,
  input  logic [15:0]        in_comms_distance,
  input  logic               out_valid,
  input  logic [7:0]         out_succ_row,
  input  logic [7:0]         out_succ_col,
  input  logic [2:0]         out_succ_heading,
  input  logic               out_empty_res,
  input  logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] col;
    logic [2:0] hd;
    logic       is_empty;
    logic       is_last;
  } succ_t;

  succ_t       succ_q[$];
  cell_t       terrain [0:65535];
  logic [14:0] turn_lim, lon_lim, lat_lim;
  logic [15:0] comms_lim;
  logic [8:0]  rows_lim, cols_lim;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int row_step(input logic [2:0] h);
    case (h)
      3'd0, 3'd1, 3'd7: return -1;
      3'd2, 3'd6:       return 0;
      default:          return 1;
    endcase
  endfunction

  function automatic int col_step(input logic [2:0] h);
    case (h)
      3'd1, 3'd2, 3'd3: return 1;
      3'd0, 3'd4:       return 0;
      default:          return -1;
    endcase
  endfunction

  function automatic int magnitude(input logic signed [15:0] v);
    int x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  // opposite headings share slopes; only magnitudes matter
  function automatic bit slopes_pass(input cell_t t, input logic [2:0] h);
    logic signed [15:0] lon, lat;
    case (h[1:0])
      2'd0: begin lon = t.north_s;     lat = t.east_s;      end
      2'd1: begin lon = t.northeast_s; lat = t.southeast_s; end
      2'd2: begin lon = t.east_s;      lat = t.north_s;     end
      default: begin lon = t.southeast_s; lat = t.northeast_s; end
    endcase
    return magnitude(lon) <= int'(lon_lim) && magnitude(lat) <= int'(lat_lim);
  endfunction

  function automatic int dim_bound(input logic [8:0] v);
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  function automatic bit step_pass(input int r, input int c, input logic [2:0] h);
    cell_t t;
    if (r < 0 || c < 0 || r >= dim_bound(rows_lim) || c >= dim_bound(cols_lim)) return 1'b0;
    t = terrain[r * 256 + c];
    if (t.comms > comms_lim) return 1'b0;
    return slopes_pass(t, h);
  endfunction

  task automatic predict_successors(input logic [7:0] r, input logic [7:0] c,
                                    input logic [2:0] h);
    cell_t here;
    succ_t found [0:3];
    succ_t s;
    int    n, fr, fc, br, bc;
    here = terrain[{r, c}];
    n = 0;
    s = '0;
    s.row = r;
    s.col = c;
    if (here.abs_s <= turn_lim) begin
      s.hd = h - 3'd1;
      found[n] = s;
      n++;
      s.hd = h + 3'd1;
      found[n] = s;
      n++;
    end
    if (slopes_pass(here, h)) begin
      fr = int'(r) + row_step(h);
      fc = int'(c) + col_step(h);
      br = int'(r) - row_step(h);
      bc = int'(c) - col_step(h);
      s.hd = h;
      if (step_pass(fr, fc, h)) begin
        s.row = 8'(fr);
        s.col = 8'(fc);
        found[n] = s;
        n++;
      end
      if (step_pass(br, bc, h)) begin
        s.row = 8'(br);
        s.col = 8'(bc);
        found[n] = s;
        n++;
      end
    end
    if (n == 0) begin
      s = '0;
      s.is_empty = 1'b1;
      s.is_last = 1'b1;
      succ_q.insert(succ_q.size(), s);
    end else begin
      found[n - 1].is_last = 1'b1;
      for (int k = 0; k < n; k++) succ_q.insert(succ_q.size(), found[k]);
    end
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    succ_t got, want;
    if (!rst_n) begin
      turn_lim  = TURN_RST;
      lon_lim   = LON_RST;
      lat_lim   = LAT_RST;
      comms_lim = COMMS_RST;
      rows_lim  = DIM_RST;
      cols_lim  = DIM_RST;
      succ_q.delete();
    end else begin
      if (out_valid) begin
        got = {out_succ_row, out_succ_col, out_succ_heading, out_empty_res, out_last};
        if (succ_q.size() == 0) begin
          note_failure($sformatf("unexpected word row %0d col %0d hd %0d empty %0b last %0b",
                                 got.row, got.col, got.hd, got.is_empty, got.is_last));
        end else begin
          want = succ_q.pop_front();
          if (got.row !== want.row || got.col !== want.col || got.hd !== want.hd ||
              got.is_empty !== want.is_empty || got.is_last !== want.is_last) begin
            note_failure($sformatf({"expected row %0d col %0d hd %0d empty %0b last %0b, ",
                                    "got row %0d col %0d hd %0d empty %0b last %0b"},
                                   want.row, want.col, want.hd, want.is_empty, want.is_last,
                                   got.row, got.col, got.hd, got.is_empty, got.is_last));
          end
        end
      end
      if (start && !busy) begin
        if (in_op == OP_LOAD) begin
          terrain[{in_cell_row, in_cell_col}] = {in_abs_slope, in_north_slope,
                                                 in_northeast_slope, in_east_slope,
                                                 in_southeast_slope, in_comms_distance};
        end else begin
          predict_successors(in_cell_row, in_cell_col, in_heading);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TURN:  turn_lim  = cfg_wdata[14:0];
          CFG_LON:   lon_lim   = cfg_wdata[14:0];
          CFG_LAT:   lat_lim   = cfg_wdata[14:0];
          CFG_COMMS: comms_lim = cfg_wdata;
          CFG_ROWS:  rows_lim  = cfg_wdata[8:0];
          CFG_COLS:  cols_lim  = cfg_wdata[8:0];
          default: ;
        endcase
      end
    end
    outstanding = succ_q.size();
  end

endmodule

// ----- dv/tb_rover_lattice_successors_unit.sv -----
// Testbench top for the lattice successor unit: stimulus, limit phases and verdict.
module tb_rover_lattice_successors_unit
  import rls_pkg::*;
  import rls_tb_pkg::*;
();

  localparam int RANDOM_WORDS = 264;
  localparam int PHASES       = 6;
  localparam int QUIET_LIMIT  = 1000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [7:0]         in_cell_row;
  logic [7:0]         in_cell_col;
  logic [2:0]         in_heading;
  logic [14:0]        in_abs_slope;
  logic signed [15:0] in_north_slope;
  logic signed [15:0] in_northeast_slope;
  logic signed [15:0] in_east_slope;
  logic signed [15:0] in_southeast_slope;
  logic [15:0]        in_comms_distance;
  logic               out_valid;
  logic [7:0]         out_succ_row;
  logic [7:0]         out_succ_col;
  logic [2:0]         out_succ_heading;
  logic               out_empty_res;
  logic               out_last;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  int                 mismatches;
  int                 outstanding;

  bit loaded [0:65535];
  int words_sent = 0;
  int tail_mark  = 1 << 30;
  int calm       = 0;
  int cur_rows   = 256;
  int cur_cols   = 256;
  int quiet      = 0;

  rover_lattice_successors_unit dut (.*);
  rls_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("rover_lattice_successors_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic logic signed [15:0] rand_slope();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 8000)) - 4000;
      4, 5:       v = int'($urandom_range(4900, 5300));
      6, 7:       v = int'($urandom_range(0, 46080)) - 23040;
      8:          v = 23040;
      default:    v = int'($urandom_range(0, 300));
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return 16'(v);
  endfunction

  function automatic cell_t random_cell();
    cell_t t;
    case ($urandom_range(0, 7))
      0, 1:    t.abs_s = 15'($urandom_range(0, 3000));
      2, 3:    t.abs_s = 15'($urandom_range(2260, 2860));
      4, 5:    t.abs_s = 15'($urandom_range(0, 23040));
      6:       t.abs_s = 15'd23040;
      default: t.abs_s = 15'd0;
    endcase
    t.north_s     = rand_slope();
    t.northeast_s = rand_slope();
    t.east_s      = rand_slope();
    t.southeast_s = rand_slope();
    case ($urandom_range(0, 5))
      0, 1, 2: t.comms = 16'($urandom_range(0, 65535));
      3, 4:    t.comms = 16'($urandom_range(0, 1000));
      default: t.comms = 16'hFFFF;
    endcase
    return t;
  endfunction

  function automatic cell_t make_cell(input logic [14:0] a, input logic signed [15:0] n,
                                      input logic signed [15:0] ne, input logic signed [15:0] e,
                                      input logic signed [15:0] se, input logic [15:0] cm);
    cell_t t;
    t.abs_s       = a;
    t.north_s     = n;
    t.northeast_s = ne;
    t.east_s      = e;
    t.southeast_s = se;
    t.comms       = cm;
    return t;
  endfunction

  // edges of the store, edge of the bounds window, or anywhere
  function automatic logic [7:0] pick_coord(input int bound);
    int v;
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, 2));
      1:       v = int'($urandom_range(253, 255));
      2:       v = bound - int'($urandom_range(0, 2));
      default: v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [8:0] rand_dim();
    case ($urandom_range(0, 3))
      0:       return 9'd1;
      1:       return 9'd2;
      2:       return 9'($urandom_range(1, 256));
      default: return 9'd256;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic put_word(input logic op, input logic [7:0] r, input logic [7:0] c,
                          input logic [2:0] h, input cell_t t);
    if (calm > 0) begin
      calm--;
    end else if (words_sent < tail_mark) begin
      if ($urandom_range(0, 9) == 0) begin
        calm = int'($urandom_range(10, 30));
      end else if ($urandom_range(0, 3) == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
    end
    start              = 1'b1;
    in_op              = op;
    in_cell_row        = r;
    in_cell_col        = c;
    in_heading         = h;
    in_abs_slope       = t.abs_s;
    in_north_slope     = t.north_s;
    in_northeast_slope = t.northeast_s;
    in_east_slope      = t.east_s;
    in_southeast_slope = t.southeast_s;
    in_comms_distance  = t.comms;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (op == OP_LOAD) loaded[{r, c}] = 1'b1;
    words_sent++;
  endtask

  // every neighbour a query may read must hold terrain
  task automatic ensure_patch(input logic [7:0] r, input logic [7:0] c);
    int rr, cc;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = int'(r) + dr;
        cc = int'(c) + dc;
        if (rr >= 0 && rr <= 255 && cc >= 0 && cc <= 255 && !loaded[rr * 256 + cc])
          put_word(OP_LOAD, 8'(rr), 8'(cc), 3'($urandom_range(0, 7)), random_cell());
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [14:0] turn, input logic [14:0] lon,
                            input logic [14:0] lat, input logic [15:0] comms,
                            input logic [8:0] rows, input logic [8:0] cols);
    start = 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(CFG_TURN, {1'b0, turn});
    write_reg(CFG_LON, {1'b0, lon});
    write_reg(CFG_LAT, {1'b0, lat});
    write_reg(CFG_COMMS, comms);
    write_reg(CFG_ROWS, {7'd0, rows});
    write_reg(CFG_COLS, {7'd0, cols});
    cfg_we   = 1'b0;
    cur_rows = int'(rows);
    cur_cols = int'(cols);
  endtask

  initial begin
    logic [7:0] r, c;
    int         phase_end;
    rst_n              = 1'b0;
    start              = 1'b0;
    in_op              = OP_LOAD;
    in_cell_row        = '0;
    in_cell_col        = '0;
    in_heading         = '0;
    in_abs_slope       = '0;
    in_north_slope     = '0;
    in_northeast_slope = '0;
    in_east_slope      = '0;
    in_southeast_slope = '0;
    in_comms_distance  = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_TURN;
    cfg_wdata          = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // top-left corner: every heading, edge of the store, most negative slope
    put_word(OP_LOAD, 8'd0, 8'd0, 3'd5, make_cell(15'd0, 0, 0, 0, 0, 16'd0));
    put_word(OP_LOAD, 8'd0, 8'd1, 3'd2, make_cell(15'd23040, 23040, -23040, 0, 0, 16'hFFFF));
    put_word(OP_LOAD, 8'd1, 8'd0, 3'd7, make_cell(15'd2560, 0, 0, 5120, -5120, 16'd100));
    put_word(OP_LOAD, 8'd1, 8'd1, 3'd0, make_cell(15'd2561, -32768, 32767, -1, 1, 16'hFFFF));
    for (int h = 0; h < 8; h++) put_word(OP_QUERY, 8'd0, 8'd0, 3'(h), random_cell());
    // bottom-right corner, steep everywhere: empty answers
    put_word(OP_LOAD, 8'd254, 8'd254, 3'd1, make_cell(15'd100, 5121, -5121, 5120, -5120, 16'd0));
    put_word(OP_LOAD, 8'd254, 8'd255, 3'd3, random_cell());
    put_word(OP_LOAD, 8'd255, 8'd254, 3'd6, random_cell());
    put_word(OP_LOAD, 8'd255, 8'd255, 3'd4,
             make_cell(15'd23040, 23040, 23040, 23040, 23040, 16'hFFFF));
    put_word(OP_QUERY, 8'd255, 8'd255, 3'd3, random_cell());
    put_word(OP_QUERY, 8'd255, 8'd255, 3'd7, random_cell());
    // limits met with equality
    put_word(OP_LOAD, 8'd0, 8'd0, 3'd0, make_cell(15'd2560, 5120, -5120, 5120, -5120, 16'd0));
    put_word(OP_QUERY, 8'd0, 8'd0, 3'd4, random_cell());
    put_word(OP_QUERY, 8'd0, 8'd0, 3'd2, random_cell());
    put_word(OP_QUERY, 8'd0, 8'd0, 3'd3, random_cell());

    tail_mark = words_sent + (RANDOM_WORDS * 85) / 100;
    phase_end = words_sent;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_limits(TURN_RST, LON_RST, LAT_RST, COMMS_RST, DIM_RST, DIM_RST);
        1: set_limits(15'd0, 15'd0, 15'd0, 16'd0, 9'd1, 9'd1);
        2: set_limits(15'd23040, 15'd23040, 15'd23040, 16'hFFFF, 9'd256, 9'd256);
        5: set_limits(15'($urandom_range(0, 23040)), 15'($urandom_range(0, 23040)),
                      15'($urandom_range(0, 23040)), 16'($urandom_range(0, 65535)),
                      9'd0, 9'h1FF);
        default: set_limits(15'($urandom_range(0, 23040)), 15'($urandom_range(0, 23040)),
                            15'($urandom_range(0, 23040)), 16'($urandom_range(0, 65535)),
                            rand_dim(), rand_dim());
      endcase
      phase_end += RANDOM_WORDS / PHASES;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          put_word(OP_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), random_cell());
        end else begin
          r = pick_coord(cur_rows - 1);
          c = pick_coord(cur_cols - 1);
          ensure_patch(r, c);
          repeat ($urandom_range(0, 2))
            put_word(OP_LOAD, 8'(int'(r) == 255 ? 255 : int'(r) + int'($urandom_range(0, 1))),
                     c, 3'($urandom_range(0, 7)), random_cell());
          repeat ($urandom_range(1, 3))
            put_word(OP_QUERY, r, c, 3'($urandom_range(0, 7)), random_cell());
        end
      end
    end

    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (mismatches == 0) $display("rover_lattice_successors_unit regression: pass");
    else $display("rover_lattice_successors_unit regression: fail");
    $finish;
  end

endmodule

// ----- rover_lattice_successors_unit.f -----
rtl/rls_pkg.sv
rtl/rls_ram.sv
rtl/rls_cell_check.sv
rtl/rover_lattice_successors_unit.sv
dv/rls_tb_pkg.sv
dv/rls_checker.sv
dv/tb_rover_lattice_successors_unit.sv
